// ===== hdl/hpm_pkg.sv =====
`default_nettype none
package hpm_pkg;

	localparam int PATTERN_SLOTS       = 8192;
	localparam int SLOT_W              = $clog2(PATTERN_SLOTS);
	localparam int COUNT_W             = SLOT_W + 1;
	localparam int MAX_WORD_LETTERS    = 32;
	localparam int BUF_IDX_W           = $clog2(MAX_WORD_LETTERS);
	localparam int WLEN_W              = BUF_IDX_W + 1;
	localparam int MAX_PATTERN_LETTERS = 9;
	localparam int LETTER_W            = 5;
	localparam int GAP_W               = 4;
	localparam int PLEN_W              = 4;
	localparam int TEXT_W              = MAX_PATTERN_LETTERS * LETTER_W;
	localparam int VALUES_W            = (MAX_PATTERN_LETTERS + 1) * GAP_W;
	localparam int ENTRY_W             = PLEN_W + VALUES_W + TEXT_W;
	localparam int SYM_N               = MAX_WORD_LETTERS + 2;
	localparam int GAP_N               = MAX_WORD_LETTERS + 3;
	localparam int THERM_W             = (1 << GAP_W) - 1;
	localparam int LEFT_MIN            = 2;
	localparam int RIGHT_MIN           = 3;

	localparam logic [LETTER_W-1:0] EDGE_DOT = LETTER_W'(27);

	typedef logic [LETTER_W-1:0] letter_t;
	typedef logic [GAP_W-1:0]    gap_t;
	typedef logic [THERM_W-1:0]  therm_t;

	// unary code of a gap value: bit j set when the value exceeds j
	function automatic therm_t to_therm(input gap_t v);
		therm_t t;
		for (int j = 0; j < THERM_W; j++) begin
			t[j] = (32'(v) > j);
		end
		return t;
	endfunction

	function automatic gap_t from_therm(input therm_t t);
		gap_t v;
		v = '0;
		for (int j = 0; j < THERM_W; j++) begin
			if (t[j]) v = GAP_W'(j + 1);
		end
		return v;
	endfunction

endpackage
`default_nettype wire

// ===== hdl/hpm_ram.sv =====
`default_nettype none
module hpm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		if (re) rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

// ===== hdl/hyphenation_pattern_matcher.sv =====
// Load items and non-final letters are accepted while the matcher is idle.
// A final letter starts a scan that reads pattern_count entries of the pattern RAM, one entry per cycle
// from its single read port, then drains the two-stage compare pipeline (the scan is skipped
// when pattern_count is zero), then emits the word one letter at a time as out_stall allows;
// the input is stalled for that whole span.
// Reset clears control state and pattern_count; the pattern table is undefined until loaded.
`default_nettype none
module hyphenation_pattern_matcher (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 cfg_we,
	input  wire logic [hpm_pkg::COUNT_W-1:0]          cfg_wdata,
	input  wire logic                                 in_valid,
	output      logic                                 in_stall,
	input  wire logic                                 kind,
	input  wire logic [12:0]                          pattern_slot,
	input  wire logic [44:0]                          pattern_text,
	input  wire logic [3:0]                           pattern_length,
	input  wire logic [39:0]                          pattern_values,
	input  wire logic [4:0]                           letter,
	input  wire logic                                 last_letter,
	output      logic                                 out_valid,
	input  wire logic                                 out_stall,
	output      logic [4:0]                           out_letter,
	output      logic                                 hyphen_after,
	output      logic                                 last,
	output      logic                                 word_overflow
);

	typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DRAIN, ST_EMIT} state_t;

	state_t                             state_q;
	logic [hpm_pkg::COUNT_W-1:0]        count_q;
	logic [hpm_pkg::COUNT_W-1:0]        cnt_q;
	logic [hpm_pkg::WLEN_W-1:0]         wlen_q;
	logic [hpm_pkg::WLEN_W-1:0]         idx_q;
	logic                               ovf_q;
	logic                               out_valid_q;
	logic [hpm_pkg::LETTER_W-1:0]       out_letter_q;
	logic                               out_hyph_q;
	logic                               out_last_q;
	logic                               out_ovf_q;

	hpm_pkg::letter_t                   buf_q [hpm_pkg::MAX_WORD_LETTERS];
	hpm_pkg::gap_t                      gap_q [hpm_pkg::GAP_N];
	hpm_pkg::letter_t                   sym [hpm_pkg::SYM_N];

	logic                               v_s1;
	logic                               v_s2;
	logic [hpm_pkg::SYM_N-1:0]          hit;
	logic [hpm_pkg::SYM_N-1:0]          hit_s2;
	logic [hpm_pkg::VALUES_W-1:0]       vals_s2;
	logic [hpm_pkg::PLEN_W-1:0]         plen_s2;

	logic [hpm_pkg::ENTRY_W-1:0]        wr_entry;
	logic [hpm_pkg::ENTRY_W-1:0]        rd_entry;
	logic [hpm_pkg::PLEN_W-1:0]         len_sat;
	logic [hpm_pkg::TEXT_W-1:0]         rd_text;
	logic [hpm_pkg::PLEN_W-1:0]         rd_plen;

	logic                               in_xfer;
	logic                               load_we;
	logic                               letter_xfer;
	logic                               start_scan;
	logic                               scan_re;
	logic                               emit_go;
	logic                               emit_last;
	logic                               emit_hyph;
	logic [hpm_pkg::WLEN_W:0]           idx_plus;
	logic [hpm_pkg::WLEN_W-1:0]         wlen_next;

	assign in_stall     = (state_q != ST_IDLE);
	assign in_xfer      = in_valid && !in_stall;
	assign load_we      = in_xfer && !kind;
	assign letter_xfer  = in_xfer && kind;
	assign start_scan   = letter_xfer && last_letter;
	assign scan_re      = (state_q == ST_SCAN);
	assign emit_go      = (state_q == ST_EMIT) && (!out_valid_q || !out_stall);
	assign emit_last    = (idx_q == wlen_q);
	assign idx_plus     = {1'b0, idx_q} + (hpm_pkg::WLEN_W+1)'(hpm_pkg::RIGHT_MIN);
	assign emit_hyph    = (32'(idx_q) >= hpm_pkg::LEFT_MIN) && (idx_plus <= {1'b0, wlen_q})
	                      && gap_q[2][0];
	assign wlen_next    = (wlen_q < hpm_pkg::WLEN_W'(hpm_pkg::MAX_WORD_LETTERS))
	                      ? wlen_q + 1'b1 : wlen_q;

	assign len_sat  = (pattern_length > hpm_pkg::PLEN_W'(hpm_pkg::MAX_PATTERN_LETTERS))
	                  ? hpm_pkg::PLEN_W'(hpm_pkg::MAX_PATTERN_LETTERS) : pattern_length;
	assign wr_entry = {len_sat, pattern_values, pattern_text};
	assign rd_text  = rd_entry[hpm_pkg::TEXT_W-1:0];
	assign rd_plen  = rd_entry[hpm_pkg::ENTRY_W-1 -: hpm_pkg::PLEN_W];

	hpm_ram #(
		.WIDTH(hpm_pkg::ENTRY_W),
		.DEPTH(hpm_pkg::PATTERN_SLOTS)
	) u_table (
		.clk   (clk),
		.we    (load_we),
		.waddr (pattern_slot),
		.wdata (wr_entry),
		.re    (scan_re),
		.raddr (cnt_q[hpm_pkg::SLOT_W-1:0]),
		.rdata (rd_entry)
	);

	// word framed by edge dots
	always_comb begin
		for (int p = 0; p < hpm_pkg::SYM_N; p++) begin
			if (p == 0 || p == 32'(wlen_q) + 1 || p > hpm_pkg::MAX_WORD_LETTERS) begin
				sym[p] = hpm_pkg::EDGE_DOT;
			end else begin
				sym[p] = buf_q[p-1];
			end
		end
	end

	// compare the entry at every start position in parallel
	always_comb begin
		for (int s = 0; s < hpm_pkg::SYM_N; s++) begin
			hit[s] = (rd_plen != '0) && (s + 32'(rd_plen) <= 32'(wlen_q) + 2);
			for (int k = 0; k < hpm_pkg::MAX_PATTERN_LETTERS; k++) begin
				if (k < 32'(rd_plen)) begin
					if (s + k < hpm_pkg::SYM_N) begin
						if (sym[s+k] != rd_text[k*hpm_pkg::LETTER_W +: hpm_pkg::LETTER_W])
							hit[s] = 1'b0;
					end else begin
						hit[s] = 1'b0;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= scan_re;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		hit_s2  <= hit;
		vals_s2 <= rd_entry[hpm_pkg::TEXT_W +: hpm_pkg::VALUES_W];
		plen_s2 <= rd_plen;
	end

	// word buffer and gap values: fill, merge matches, shift out
	always_ff @(posedge clk) begin
		hpm_pkg::therm_t t;
		if (letter_xfer && (wlen_q < hpm_pkg::WLEN_W'(hpm_pkg::MAX_WORD_LETTERS))) begin
			buf_q[wlen_q[hpm_pkg::BUF_IDX_W-1:0]] <= letter;
		end
		if (start_scan) begin
			for (int g = 0; g < hpm_pkg::GAP_N; g++) gap_q[g] <= '0;
		end else if (v_s2) begin
			for (int g = 0; g < hpm_pkg::GAP_N; g++) begin
				t = hpm_pkg::to_therm(gap_q[g]);
				for (int k = 0; k <= hpm_pkg::MAX_PATTERN_LETTERS; k++) begin
					if (g - k >= 0 && g - k < hpm_pkg::SYM_N && k <= 32'(plen_s2)) begin
						if (hit_s2[g-k])
							t = t | hpm_pkg::to_therm(vals_s2[k*hpm_pkg::GAP_W +: hpm_pkg::GAP_W]);
					end
				end
				gap_q[g] <= hpm_pkg::from_therm(t);
			end
		end else if (emit_go) begin
			for (int g = 0; g < hpm_pkg::GAP_N - 1; g++) gap_q[g] <= gap_q[g+1];
			gap_q[hpm_pkg::GAP_N-1] <= '0;
		end
		if (emit_go) begin
			for (int b = 0; b < hpm_pkg::MAX_WORD_LETTERS - 1; b++) buf_q[b] <= buf_q[b+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			cnt_q       <= '0;
			wlen_q      <= '0;
			idx_q       <= '0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				count_q <= (cfg_wdata > hpm_pkg::COUNT_W'(hpm_pkg::PATTERN_SLOTS))
				           ? hpm_pkg::COUNT_W'(hpm_pkg::PATTERN_SLOTS) : cfg_wdata;
			end
			if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (letter_xfer) begin
						wlen_q <= wlen_next;
						if (wlen_q == hpm_pkg::WLEN_W'(hpm_pkg::MAX_WORD_LETTERS)) ovf_q <= 1'b1;
						if (last_letter) begin
							cnt_q   <= '0;
							state_q <= (count_q == '0) ? ST_DRAIN : ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == count_q - 1'b1) state_q <= ST_DRAIN;
				end
				ST_DRAIN: begin
					if (!v_s1 && !v_s2) begin
						idx_q   <= hpm_pkg::WLEN_W'(1);
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (emit_go) begin
						out_valid_q  <= 1'b1;
						out_letter_q <= buf_q[0];
						out_hyph_q   <= emit_hyph;
						out_last_q   <= emit_last;
						out_ovf_q    <= ovf_q;
						idx_q        <= idx_q + 1'b1;
						if (emit_last) begin
							wlen_q  <= '0;
							ovf_q   <= 1'b0;
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign out_letter    = out_letter_q;
	assign hyphen_after  = out_hyph_q;
	assign last          = out_last_q;
	assign word_overflow = out_ovf_q;

	a_idle_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!in_stall |-> !v_s1 && !v_s2)
		else $error("scan pipeline busy while accepting input");

	a_wlen_cap: assert property (@(posedge clk) disable iff (!arst_n)
		wlen_q <= hpm_pkg::WLEN_W'(hpm_pkg::MAX_WORD_LETTERS))
		else $error("word length beyond buffer");

	a_emit_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMIT |-> idx_q != '0 && idx_q <= wlen_q)
		else $error("emit index out of word");

endmodule
`default_nettype wire
